@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/srds_pkg.sv @@
// ----------------------------------------------------------------------------
// srds_pkg
// Types and constants shared by the stick deadzone scaler and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srds_pkg;

  // Output full scale and deadzone ceiling (0.60 in Q0.16).
  localparam int OUT_RANGE = 80;
  localparam logic [15:0] DZ_MAX = 16'd39321;

  // Number of cells in each chain.
  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS  = 17;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEADZONE = 2'd0;
  localparam logic [1:0] CFG_INVERT_X = 2'd1;
  localparam logic [1:0] CFG_INVERT_Y = 2'd2;
  localparam logic [1:0] CFG_USE_RIGHT = 2'd3;

  // Input transaction payload.
  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic               pad_present;
    logic               key_left;
    logic               key_right;
    logic               key_up;
    logic               key_down;
  } srds_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } srds_out_t;

  // Sample data carried alongside the arithmetic through every cell.
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [16:0] abs_x;
    logic [16:0] abs_y;
    logic [16:0] mag;
    logic        zero;
    logic        sat;
    logic        key_left;
    logic        key_right;
    logic        key_up;
    logic        key_down;
  } srds_side_t;

  // Square root working state: remaining radicand, partial remainder, root.
  typedef struct packed {
    logic [33:0] rad;
    logic [18:0] rem;
    logic [16:0] root;
  } srds_sqrt_t;

  // Division lane working state: remainder, divisor, dividend bits, quotient.
  typedef struct packed {
    logic [17:0] rem;
    logic [17:0] den;
    logic [16:0] num;
    logic [16:0] quo;
  } srds_div_t;

endpackage

@@ design/stick_radial_deadzone_scaler.sv @@
// ----------------------------------------------------------------------------
// stick_radial_deadzone_scaler
// Radial deadzone and rescaling of one selected analog stick, with digital
// key override, inversion and conversion to a signed output range.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Direction
//  in        in_valid_i / in_ready_o / in_data_i   sample in
//  out       out_valid_o / out_ready_i / out_data_o result out
//  cfg       cfg_we_i / cfg_idx_i / cfg_wdata_i    register write
//
//  One sample enters per cycle unless the output stalls; the pipeline is two front stages,
//  17 square root cells, 17 scale-factor divider cells, one multiply stage,
//  17 axis divider cells and the output register.
//  Every stage has its own valid bit, so bubbles close up under a stall.
//  Reset clears the valid bits and the configuration registers only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stick_radial_deadzone_scaler import srds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  srds_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output srds_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // Normalize a raw axis to sign and Q1.16 magnitude.
  function automatic logic [17:0] norm_axis(input logic [15:0] v);
    logic [17:0] q4;
    logic [16:0] nv;
    logic [16:0] t;
    logic [16:0] mag;
    q4 = {1'b0, v[14:0], 2'b00} + 18'd32767;
    nv = 17'd0 - {v[15], v};
    t  = (q4 >= 18'd131068) ? 17'd2 : ((q4 >= 18'd65534) ? 17'd1 : 17'd0);
    if (v[15]) begin
      mag = {nv[15:0], 1'b0};
    end else begin
      mag = {1'b0, v[14:0], 1'b0} + t;
    end
    return {v[15], mag};
  endfunction

  // Scale a Q1.16 magnitude to the output range, rounding half away from zero.
  function automatic logic [7:0] to_out(input logic [16:0] m, input logic neg);
    logic [23:0] p;
    logic [7:0]  r;
    p = 24'(m) * 24'(OUT_RANGE * 2) + 24'h010000;
    r = {1'b0, p[23:17]};
    return neg ? (8'd0 - r) : r;
  endfunction

  // Configuration registers.
  logic [15:0] dz_q;
  logic        inv_x_q, inv_y_q, right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= '0;
      inv_x_q <= 1'b0;
      inv_y_q <= 1'b0;
      right_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEADZONE:  dz_q    <= cfg_wdata_i;
        CFG_INVERT_X:  inv_x_q <= cfg_wdata_i[0];
        CFG_INVERT_Y:  inv_y_q <= cfg_wdata_i[0];
        CFG_USE_RIGHT: right_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Chain wiring; element i feeds cell i, element i+1 is its result.
  logic            sq_v   [SQRT_STEPS+1];
  logic            sq_rdy [SQRT_STEPS+1];
  srds_sqrt_t      sq_s   [SQRT_STEPS+1];
  srds_side_t      sq_sd  [SQRT_STEPS+1];
  logic            sd_v   [DIV_STEPS+1];
  logic            sd_rdy [DIV_STEPS+1];
  srds_div_t [1:0] sd_l   [DIV_STEPS+1];
  srds_side_t      sd_sd  [DIV_STEPS+1];
  logic            ad_v   [DIV_STEPS+1];
  logic            ad_rdy [DIV_STEPS+1];
  srds_div_t [1:0] ad_l   [DIV_STEPS+1];
  srds_side_t      ad_sd  [DIV_STEPS+1];

  // Stage enables of the stages built here.
  logic en_p1, en_p2, en_m, en_f;

  // Front stage 1: select the stick and normalize both axes.
  logic        p1_v_q;
  srds_side_t  p1_q, p1_d;
  logic [17:0] nx, ny;

  always_comb begin
    nx = norm_axis(right_q ? in_data_i.right_x : in_data_i.left_x);
    ny = norm_axis(right_q ? in_data_i.right_y : in_data_i.left_y);
    p1_d           = '0;
    p1_d.neg_x     = nx[17];
    p1_d.neg_y     = ny[17];
    p1_d.abs_x     = in_data_i.pad_present ? nx[16:0] : 17'd0;
    p1_d.abs_y     = in_data_i.pad_present ? ny[16:0] : 17'd0;
    p1_d.key_left  = in_data_i.key_left;
    p1_d.key_right = in_data_i.key_right;
    p1_d.key_up    = in_data_i.key_up;
    p1_d.key_down  = in_data_i.key_down;
  end

  assign en_p1      = !p1_v_q || en_p2;
  assign in_ready_o = en_p1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en_p1) begin
      p1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p1) begin
      p1_q <= p1_d;
    end
  end

  // Front stage 2: squared vector length.
  logic        p2_v_q;
  srds_side_t  p2_q;
  logic [33:0] n_q;

  assign en_p2 = !p2_v_q || sq_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en_p2) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p2) begin
      n_q  <= 34'(p1_q.abs_x) * 34'(p1_q.abs_x) + 34'(p1_q.abs_y) * 34'(p1_q.abs_y);
      p2_q <= p1_q;
    end
  end

  // Square root chain.
  assign sq_v[0]  = p2_v_q;
  assign sq_s[0]  = '{rad: n_q, rem: 19'd0, root: 17'd0};
  assign sq_sd[0] = p2_q;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    srds_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sq_v[i]),
      .in_ready_o  (sq_rdy[i]),
      .in_step_i   (sq_s[i]),
      .in_side_i   (sq_sd[i]),
      .out_valid_o (sq_v[i+1]),
      .out_ready_i (sq_rdy[i+1]),
      .out_step_o  (sq_s[i+1]),
      .out_side_o  (sq_sd[i+1])
    );
  end

  // Deadzone test and setup of the scale-factor division.
  logic [15:0] dz;
  logic [16:0] mag, den, dz_diff;
  srds_side_t  s0_side;

  always_comb begin
    dz      = (dz_q > DZ_MAX) ? DZ_MAX : dz_q;
    mag     = sq_s[SQRT_STEPS].root;
    den     = 17'h10000 - {1'b0, dz};
    dz_diff = mag - {1'b0, dz};
    s0_side      = sq_sd[SQRT_STEPS];
    s0_side.mag  = mag;
    s0_side.zero = (mag <= {1'b0, dz});
    s0_side.sat  = (dz_diff >= den);
  end

  assign sq_rdy[SQRT_STEPS] = sd_rdy[0];
  assign sd_v[0]  = sq_v[SQRT_STEPS];
  assign sd_l[0][0] = '{rem: {1'b0, dz_diff}, den: {den, 1'b0}, num: den, quo: 17'd0};
  assign sd_l[0][1] = '0;
  assign sd_sd[0] = s0_side;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_sdiv
    srds_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sd_v[i]),
      .in_ready_o  (sd_rdy[i]),
      .in_lane_i   (sd_l[i]),
      .in_side_i   (sd_sd[i]),
      .out_valid_o (sd_v[i+1]),
      .out_ready_i (sd_rdy[i+1]),
      .out_lane_o  (sd_l[i+1]),
      .out_side_o  (sd_sd[i+1])
    );
  end

  // Multiply stage: axis magnitudes times the clamped scale factor.
  logic        m_v_q;
  srds_side_t  m_q;
  logic [32:0] px_q, py_q;
  logic [16:0] sf;

  assign sf    = sd_sd[DIV_STEPS].sat ? 17'h10000 : sd_l[DIV_STEPS][0].quo;
  assign en_m  = !m_v_q || ad_rdy[0];
  assign sd_rdy[DIV_STEPS] = en_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en_m) begin
      m_v_q <= sd_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m) begin
      px_q <= 33'(sd_sd[DIV_STEPS].abs_x) * 33'(sf);
      py_q <= 33'(sd_sd[DIV_STEPS].abs_y) * 33'(sf);
      m_q  <= sd_sd[DIV_STEPS];
    end
  end

  // Axis division setup: rounded px / mag and py / mag.
  logic [33:0] num_x, num_y;

  assign num_x = {px_q, 1'b0} + 34'(m_q.mag);
  assign num_y = {py_q, 1'b0} + 34'(m_q.mag);

  assign ad_v[0]    = m_v_q;
  assign ad_l[0][0] = '{rem: {1'b0, num_x[33:17]}, den: {m_q.mag, 1'b0},
                        num: num_x[16:0], quo: 17'd0};
  assign ad_l[0][1] = '{rem: {1'b0, num_y[33:17]}, den: {m_q.mag, 1'b0},
                        num: num_y[16:0], quo: 17'd0};
  assign ad_sd[0]   = m_q;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_adiv
    srds_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (ad_v[i]),
      .in_ready_o  (ad_rdy[i]),
      .in_lane_i   (ad_l[i]),
      .in_side_i   (ad_sd[i]),
      .out_valid_o (ad_v[i+1]),
      .out_ready_i (ad_rdy[i+1]),
      .out_lane_o  (ad_l[i+1]),
      .out_side_o  (ad_sd[i+1])
    );
  end

  // Output stage: deadzone zeroing, key override, inversion, range scaling.
  logic        out_v_q;
  srds_out_t   out_q, out_d;
  srds_side_t  f_side;
  logic [16:0] fx, fy;
  logic        fnx, fny;

  always_comb begin
    f_side = ad_sd[DIV_STEPS];
    fx  = f_side.zero ? 17'd0 : ad_l[DIV_STEPS][0].quo;
    fy  = f_side.zero ? 17'd0 : ad_l[DIV_STEPS][1].quo;
    fnx = f_side.neg_x;
    fny = f_side.neg_y;
    if (f_side.key_left != f_side.key_right) begin
      fx  = 17'h10000;
      fnx = f_side.key_left;
    end
    if (f_side.key_up != f_side.key_down) begin
      fy  = 17'h10000;
      fny = f_side.key_up;
    end
    fnx = fnx ^ inv_x_q;
    fny = fny ^ inv_y_q;
    out_d.stick_x = to_out(fx, fnx);
    out_d.stick_y = to_out(fy, !fny);
  end

  assign en_f = !out_v_q || out_ready_i;
  assign ad_rdy[DIV_STEPS] = en_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_f) begin
      out_v_q <= ad_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // A taken output frees every stage, so the input side must be open.
  `ASSERT_IMPLY(a_ready_chain, clk_i, rst_ni, out_ready_i, in_ready_o)
  // A waiting result is never dropped by the output stage.
  `ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // Results stay within the output range.
  `ASSERT_IMPLY(a_range, clk_i, rst_ni, out_valid_o, ($signed(out_data_o.stick_x) <= OUT_RANGE) && ($signed(out_data_o.stick_x) >= -OUT_RANGE) && ($signed(out_data_o.stick_y) <= OUT_RANGE) && ($signed(out_data_o.stick_y) >= -OUT_RANGE))

endmodule

@@ design/srds_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// srds_sqrt_cell
// One digit of a restoring integer square root, registered, with flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srds_sqrt_cell import srds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  srds_sqrt_t in_step_i,
  input  srds_side_t in_side_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output srds_sqrt_t out_step_o,
  output srds_side_t out_side_o
);

  logic       valid_q;
  logic       en;
  logic [20:0] rem_sh;
  logic [20:0] trial;
  logic        ge;
  logic [20:0] diff;
  srds_sqrt_t  step_d, step_q;
  srds_side_t  side_q;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {in_step_i.rem, in_step_i.rad[33:32]};
    trial  = {2'b00, in_step_i.root, 2'b01};
    ge     = (rem_sh >= trial);
    diff   = rem_sh - trial;
    step_d.rad  = {in_step_i.rad[31:0], 2'b00};
    step_d.rem  = ge ? diff[18:0] : rem_sh[18:0];
    step_d.root = {in_step_i.root[15:0], ge};
  end

  // The cell moves when its slot is empty or its neighbor takes the data.
  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      step_q <= step_d;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_step_o  = step_q;
  assign out_side_o  = side_q;

endmodule

@@ design/srds_div_cell.sv @@
// ----------------------------------------------------------------------------
// srds_div_cell
// One quotient bit of two restoring division lanes, registered, with flow
// control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srds_div_cell import srds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  srds_div_t [1:0] in_lane_i,
  input  srds_side_t      in_side_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output srds_div_t [1:0] out_lane_o,
  output srds_side_t      out_side_o
);

  logic            valid_q;
  logic            en;
  logic [18:0]     r2   [2];
  logic [18:0]     sub  [2];
  logic            ge   [2];
  srds_div_t [1:0] lane_d, lane_q;
  srds_side_t      side_q;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r2[l]  = {in_lane_i[l].rem, in_lane_i[l].num[16]};
      ge[l]  = (r2[l] >= {1'b0, in_lane_i[l].den});
      sub[l] = r2[l] - {1'b0, in_lane_i[l].den};
      lane_d[l].rem = ge[l] ? sub[l][17:0] : r2[l][17:0];
      lane_d[l].den = in_lane_i[l].den;
      lane_d[l].num = {in_lane_i[l].num[15:0], 1'b0};
      lane_d[l].quo = {in_lane_i[l].quo[15:0], ge[l]};
    end
  end

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_q <= lane_d;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_lane_o  = lane_q;
  assign out_side_o  = side_q;

endmodule
